@@ sv/tsf_pkg.sv @@
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants for the triangle solver
// Fixed-point formats, the shape code and the CORDIC angle constants in degrees.
// ----------------------------------------------------------------------------
package tsf_pkg;

	localparam int ACC_FRAC     = 24;  // fraction bits of the CORDIC angle accumulator
	localparam int CORDIC_STEPS = 31;
	localparam int NORM_FRAC    = 30;  // extra root bits kept for angle normalization
	localparam int NORM_W       = 5;   // width of a normalization shift (0..30)
	localparam int CORDIC_W     = 34;  // signed width of the X, Y and Z datapaths

	typedef enum logic [1:0] {
		SHAPE_EQUILATERAL = 2'd0,
		SHAPE_ISOSCELES   = 2'd1,
		SHAPE_SCALENE     = 2'd2
	} shape_t;

	// Bitwise restoring divide, elaboration time only.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		int k;
		r = '0;
		q = '0;
		for (k = 63; k >= 0; k--) begin
			r = {r[63:0], num[k]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/n) in Q2.60 radians by the alternating series
	function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] nn;
		logic [63:0] p;
		logic [63:0] t;
		logic signed [63:0] s;
		int k;
		nn = n * n;
		p = udiv64(64'd1 << 60, n);
		s = '0;
		for (k = 0; k < 64; k++) begin
			if (p != 64'd0) begin
				t = udiv64(p, 64'(2 * k + 1));
				if (k[0])
					s = s - $signed(t);
				else
					s = s + $signed(t);
				p = udiv64(p, nn);
			end
		end
		return s;
	endfunction

	// atan(2^-i) in degrees, ACC_FRAC fraction bits
	function automatic logic [63:0] atan_deg(input int i);
		logic [63:0] q28;
		logic [63:0] v28;
		q28 = $unsigned(atan_recip(64'd2) + atan_recip(64'd3)) >> 28;
		v28 = $unsigned(atan_recip(64'd1 << i)) >> 28;
		if (i == 0)
			return 64'd45 << ACC_FRAC;
		return udiv64((v28 * 64'd45) << ACC_FRAC, q28);
	endfunction

endpackage

@@ sv/tsf_front.sv @@
// ----------------------------------------------------------------------------
// tsf_front: side sums, products and Heron product
// Three stages: sums and checks, squares and partial products, Heron product
// with the law-of-cosines numerators and the normalization shifts.
// ----------------------------------------------------------------------------
module tsf_front import tsf_pkg::*; #(
	parameter int SW = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SW-1:0]            in_a,
	input  logic [SW-1:0]            in_b,
	input  logic [SW-1:0]            in_c,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [4*SW+1:0]          out_prod,
	output logic [SW+1:0]            out_per,
	output shape_t                   out_cls,
	output logic                     out_ok,
	output logic signed [2*SW+1:0]   out_x [3],
	output logic [NORM_W-1:0]        out_h [3]
);

	localparam int PW = 4 * SW + 2;
	localparam int XW = 2 * SW + 2;
	localparam int MW = 2 * SW + 1;

	// h = 30 - bitlength(m): largest shift keeping m*2^h below 2^30
	function automatic logic [NORM_W-1:0] norm_shift(input logic [MW-1:0] m);
		logic [NORM_W-1:0] bl;
		int k;
		bl = '0;
		for (k = 0; k < MW; k++) begin
			if (m[k])
				bl = NORM_W'(k + 1);
		end
		return NORM_W'(NORM_FRAC) - bl;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic [SW-1:0]   a_s1, b_s1, c_s1;
	logic [SW+1:0]   per_s1, per_s2, per_s3;
	logic [SW:0]     d_s1 [3];
	logic            ok_s1, ok_s2, ok_s3;
	shape_t          cls_s1, cls_s2, cls_s3;

	logic [2*SW+2:0] p1_s2;
	logic [2*SW+1:0] p2_s2;
	logic [2*SW-1:0] sq_s2 [3];
	logic [2*SW-1:0] pr_s2 [3];

	logic [PW-1:0]          prod_s3;
	logic signed [XW-1:0]   x_s3 [3];
	logic [NORM_W-1:0]      h_s3 [3];

	logic [SW:0]     sab, sac, sbc;
	logic            ok_c;
	shape_t          cls_c;
	logic [4*SW+4:0] prod_full;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign sab = {1'b0, in_a} + {1'b0, in_b};
	assign sac = {1'b0, in_a} + {1'b0, in_c};
	assign sbc = {1'b0, in_b} + {1'b0, in_c};

	always_comb begin
		ok_c = (in_a != '0) && (in_b != '0) && (in_c != '0) &&
			(sab > {1'b0, in_c}) && (sac > {1'b0, in_b}) && (sbc > {1'b0, in_a});
		if (in_a == in_b && in_b == in_c)
			cls_c = SHAPE_EQUILATERAL;
		else if (in_a == in_b || in_b == in_c || in_a == in_c)
			cls_c = SHAPE_ISOSCELES;
		else
			cls_c = SHAPE_SCALENE;
	end

	assign prod_full = p1_s2 * p2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			a_s1    <= in_a;
			b_s1    <= in_b;
			c_s1    <= in_c;
			per_s1  <= {2'b00, in_a} + {2'b00, in_b} + {2'b00, in_c};
			d_s1[0] <= sbc - {1'b0, in_a};
			d_s1[1] <= sac - {1'b0, in_b};
			d_s1[2] <= sab - {1'b0, in_c};
			ok_s1   <= ok_c;
			cls_s1  <= cls_c;
		end
		if (rdy2 && v_s1) begin
			p1_s2    <= per_s1 * d_s1[0];
			p2_s2    <= d_s1[1] * d_s1[2];
			sq_s2[0] <= a_s1 * a_s1;
			sq_s2[1] <= b_s1 * b_s1;
			sq_s2[2] <= c_s1 * c_s1;
			pr_s2[0] <= b_s1 * c_s1;
			pr_s2[1] <= a_s1 * c_s1;
			pr_s2[2] <= a_s1 * b_s1;
			per_s2   <= per_s1;
			ok_s2    <= ok_s1;
			cls_s2   <= cls_s1;
		end
		if (rdy3 && v_s2) begin
			prod_s3 <= prod_full[PW-1:0];
			x_s3[0] <= $signed({2'b00, sq_s2[1]}) + $signed({2'b00, sq_s2[2]})
				- $signed({2'b00, sq_s2[0]});
			x_s3[1] <= $signed({2'b00, sq_s2[0]}) + $signed({2'b00, sq_s2[2]})
				- $signed({2'b00, sq_s2[1]});
			x_s3[2] <= $signed({2'b00, sq_s2[0]}) + $signed({2'b00, sq_s2[1]})
				- $signed({2'b00, sq_s2[2]});
			h_s3[0] <= norm_shift({pr_s2[0], 1'b0});
			h_s3[1] <= norm_shift({pr_s2[1], 1'b0});
			h_s3[2] <= norm_shift({pr_s2[2], 1'b0});
			per_s3  <= per_s2;
			ok_s3   <= ok_s2;
			cls_s3  <= cls_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_prod  = prod_s3;
	assign out_per   = per_s3;
	assign out_cls   = cls_s3;
	assign out_ok    = ok_s3;
	assign out_x     = x_s3;
	assign out_h     = h_s3;

endmodule

@@ sv/tsf_isqrt.sv @@
// ----------------------------------------------------------------------------
// tsf_isqrt: pipelined integer square root
// One root bit per stage of floor(sqrt(prod * 2^(2*NORM_FRAC))); a side
// vector travels alongside each item.
// ----------------------------------------------------------------------------
module tsf_isqrt import tsf_pkg::*; #(
	parameter int PW  = 50,
	parameter int SCW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PW-1:0]                 in_prod,
	input  logic [SCW-1:0]                in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [(PW+2*NORM_FRAC)/2-1:0] out_root,
	output logic [SCW-1:0]                out_side
);

	localparam int RTW = (PW + 2 * NORM_FRAC) / 2;
	localparam int RMW = RTW + 2;

	logic            v_s    [RTW];
	logic [RMW-1:0]  rem_s  [RTW];
	logic [RTW-1:0]  root_s [RTW];
	logic [PW-1:0]   prod_s [RTW];
	logic [SCW-1:0]  side_s [RTW];
	logic [RTW:0]    rdy;

	assign rdy[RTW] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < RTW; k++) begin : g_stg
		localparam int P = RTW - 1 - k;  // radicand digit pair handled here
		logic [RMW-1:0] rem_in, rem_sh, trial, rem_nx;
		logic [RTW-1:0] root_in;
		logic [PW-1:0]  prod_in;
		logic [SCW-1:0] side_in;
		logic           v_in, ge;
		logic [1:0]     pair;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign prod_in = in_prod;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_body
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign prod_in = prod_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// low pairs of the scaled radicand are zero
		if (P >= NORM_FRAC) begin : g_data
			assign pair = prod_in[2*(P-NORM_FRAC)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_sh = {rem_in[RMW-3:0], pair};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;
		assign rem_nx = ge ? rem_sh - trial : rem_sh;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (rdy[k])
				v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				rem_s[k]  <= rem_nx;
				root_s[k] <= {root_in[RTW-2:0], ge};
				prod_s[k] <= prod_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = v_s[RTW-1];
	assign out_root  = root_s[RTW-1];
	assign out_side  = side_s[RTW-1];

endmodule

@@ sv/tsf_cordic.sv @@
// ----------------------------------------------------------------------------
// tsf_cordic: three-lane vectoring CORDIC for the interior angles
// A setup stage scales X and Y, one stage per rotation, and a last stage
// folds obtuse angles, rounds to the output format and zeroes invalid items.
// ----------------------------------------------------------------------------
module tsf_cordic import tsf_pkg::*; #(
	parameter int SW  = 12,
	parameter int AF  = 8,
	parameter int RTW = 55,
	parameter int SCW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [RTW-1:0]         in_root,
	input  logic signed [2*SW+1:0] in_x [3],
	input  logic [NORM_W-1:0]      in_h [3],
	input  logic                   in_ok,
	input  logic [SCW-1:0]         in_side,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [AF+7:0]          out_ang [3],
	output logic [SCW-1:0]         out_side
);

	localparam int XW  = 2 * SW + 2;
	localparam int AW  = AF + 8;
	localparam int CW  = CORDIC_W;
	localparam int NST = CORDIC_STEPS + 2;
	localparam logic signed [CW-1:0] Z180 = CW'(64'd180 << ACC_FRAC);
	localparam logic [CW-1:0] RND  = CW'(64'd1 << (ACC_FRAC - AF - 1));
	localparam logic [CW-1:0] AMAX = CW'(64'd180 << AF);

	logic                 v_s    [NST];
	logic [SCW-1:0]       side_s [NST];
	logic                 ok_s   [NST];
	logic                 obt_s  [NST-1][3];
	logic signed [CW-1:0] x_s    [NST-1][3];
	logic signed [CW-1:0] y_s    [NST-1][3];
	logic signed [CW-1:0] z_s    [NST-1][3];
	logic [AW-1:0]        ang_s  [3];
	logic [NST:0]         rdy;

	assign rdy[NST] = out_ready;
	assign in_ready = rdy[0];

	for (genvar n = 0; n < NST; n++) begin : g_stg
		logic           v_in, ok_in;
		logic [SCW-1:0] side_in;

		if (n == 0) begin : g_head
			assign v_in    = in_valid;
			assign ok_in   = in_ok;
			assign side_in = in_side;
		end else begin : g_body
			assign v_in    = v_s[n-1];
			assign ok_in   = ok_s[n-1];
			assign side_in = side_s[n-1];
		end

		assign rdy[n] = !v_s[n] || rdy[n+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[n] <= 1'b0;
			else if (rdy[n])
				v_s[n] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (rdy[n] && v_in) begin
				ok_s[n]   <= ok_in;
				side_s[n] <= side_in;
			end
		end

		if (n == 0) begin : g_setup
			logic signed [CW-1:0] x0 [3];
			logic signed [CW-1:0] y0 [3];
			logic [XW-1:0]        xmag;
			logic [RTW-1:0]       rsh;

			// X = |x| << h, Y = floor(sqrt(prod) * 2^h)
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					xmag  = in_x[j][XW-1] ? XW'(-in_x[j]) : XW'(in_x[j]);
					x0[j] = $signed(CW'(xmag) << in_h[j]);
					rsh   = in_root >> (NORM_W'(NORM_FRAC) - in_h[j]);
					y0[j] = $signed(rsh[CW-1:0]);
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[n] && v_in) begin
					for (int j = 0; j < 3; j++) begin
						x_s[n][j]   <= x0[j];
						y_s[n][j]   <= y0[j];
						z_s[n][j]   <= '0;
						obt_s[n][j] <= in_x[j][XW-1];
					end
				end
			end
		end else if (n <= CORDIC_STEPS) begin : g_rot
			localparam int I = n - 1;
			localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_deg(I)));
			logic signed [CW-1:0] xn [3];
			logic signed [CW-1:0] yn [3];
			logic signed [CW-1:0] zn [3];
			logic signed [CW-1:0] xc, yc, zc, dx, dy;
			logic [CW-1:0]        ym, xm, dym, dxm;

			// shifts truncate toward zero
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					xc  = x_s[n-1][j];
					yc  = y_s[n-1][j];
					zc  = z_s[n-1][j];
					ym  = yc[CW-1] ? -yc : yc;
					xm  = xc[CW-1] ? -xc : xc;
					dxm = ym >> I;
					dym = xm >> I;
					dx  = $signed(yc[CW-1] ? -dxm : dxm);
					dy  = $signed(xc[CW-1] ? -dym : dym);
					if (!yc[CW-1] && yc != '0) begin
						xn[j] = xc + dx;
						yn[j] = yc - dy;
						zn[j] = zc + ATAN;
					end else if (yc[CW-1]) begin
						xn[j] = xc - dx;
						yn[j] = yc + dy;
						zn[j] = zc - ATAN;
					end else begin
						xn[j] = xc;
						yn[j] = yc;
						zn[j] = zc;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[n] && v_in) begin
					for (int j = 0; j < 3; j++) begin
						x_s[n][j]   <= xn[j];
						y_s[n][j]   <= yn[j];
						z_s[n][j]   <= zn[j];
						obt_s[n][j] <= obt_s[n-1][j];
					end
				end
			end
		end else begin : g_round
			logic [AW-1:0]        an [3];
			logic signed [CW-1:0] za, zb;
			logic [CW-1:0]        r;

			always_comb begin
				for (int j = 0; j < 3; j++) begin
					za = z_s[n-1][j][CW-1] ? '0 : z_s[n-1][j];
					zb = obt_s[n-1][j] ? Z180 - za : za;
					if (zb[CW-1])
						zb = '0;
					r = ($unsigned(zb) + RND) >> (ACC_FRAC - AF);
					if (r > AMAX)
						r = AMAX;
					an[j] = ok_in ? r[AW-1:0] : '0;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[n] && v_in) begin
					for (int j = 0; j < 3; j++)
						ang_s[j] <= an[j];
				end
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign out_side  = side_s[NST-1];
	assign out_ang   = ang_s;

endmodule

@@ sv/triangle_solver_from_sides.sv @@
// ----------------------------------------------------------------------------
// triangle_solver_from_sides: Heron area and law-of-cosines angles
// Pipelined solver, one triangle per clock while the output is not stalled, from three side lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries the three side lengths of one triangle per
//   item. Output stream m_axis carries one result item per input item, in
//   order: perimeter, four times the area, the three angles in degrees with
//   ANGLE_FRAC_BITS fraction bits, the shape code, and in tuser a flag set
//   when the sides form a proper triangle (area and angles are zero if not).
//   The pipeline holds three front stages, one stage per root bit of the square
//   root, and 33 CORDIC stages.
//   Throughput is one item per cycle; each stage has its own valid bit and
//   takes a new item whenever it is empty or moves on, so bubbles close up
//   and a stalled output register still lets items enter until the
//   pipeline is full. When the receiver holds tready low, every item stays
//   where it is; none is dropped or repeated.
//   Reset empties the pipeline; no result is presented after it until new
//   items have been taken.
// ----------------------------------------------------------------------------
module triangle_solver_from_sides import tsf_pkg::*; #(
	parameter int SIDE_WIDTH      = 12,
	parameter int ANGLE_FRAC_BITS = 8,
	localparam int IN_W  = ((3 * SIDE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((SIDE_WIDTH + 2 + 2 * SIDE_WIDTH + 1 +
		3 * (ANGLE_FRAC_BITS + 8) + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// side_a, side_b, side_c
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// perimeter, area_quarters, angle_a, angle_b, angle_c, shape_class
	output logic [OUT_W-1:0] m_axis_tdata,
	// valid_res
	output logic             m_axis_tuser
);

	localparam int SW    = SIDE_WIDTH;
	localparam int AW    = ANGLE_FRAC_BITS + 8;
	localparam int PW    = 4 * SW + 2;
	localparam int XW    = 2 * SW + 2;
	localparam int PERW  = SW + 2;
	localparam int AREAW = 2 * SW + 1;
	localparam int RTW   = (PW + 2 * NORM_FRAC) / 2;
	// side vector through the root: per, cls, ok, x[3], h[3]
	localparam int O_CLS = PERW;
	localparam int O_OK  = O_CLS + 2;
	localparam int O_X   = O_OK + 1;
	localparam int O_H   = O_X + 3 * XW;
	localparam int SC1W  = O_H + 3 * NORM_W;
	// side vector through the CORDIC: per, cls, area
	localparam int SC2W  = PERW + 2 + AREAW;
	localparam logic [AW-1:0] ANG_MAX = AW'(64'd180 << ANGLE_FRAC_BITS);

	logic                 fr_valid, fr_ready;
	logic [PW-1:0]        fr_prod;
	logic [PERW-1:0]      fr_per;
	shape_t               fr_cls;
	logic                 fr_ok;
	logic signed [XW-1:0] fr_x [3];
	logic [NORM_W-1:0]    fr_h [3];

	logic                 sq_valid, sq_ready;
	logic [RTW-1:0]       sq_root;
	logic [SC1W-1:0]      sq_side;
	logic signed [XW-1:0] sq_x [3];
	logic [NORM_W-1:0]    sq_h [3];
	logic [AREAW-1:0]     sq_area;

	logic [SC2W-1:0]      co_side;
	logic [AW-1:0]        co_ang [3];
	logic [PERW-1:0]      res_per;
	logic [1:0]           res_cls;
	logic [AREAW-1:0]     res_area;

	tsf_front #(.SW(SW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_a      (s_axis_tdata[SW-1:0]),
		.in_b      (s_axis_tdata[2*SW-1:SW]),
		.in_c      (s_axis_tdata[3*SW-1:2*SW]),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_prod  (fr_prod),
		.out_per   (fr_per),
		.out_cls   (fr_cls),
		.out_ok    (fr_ok),
		.out_x     (fr_x),
		.out_h     (fr_h)
	);

	tsf_isqrt #(.PW(PW), .SCW(SC1W)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_prod   (fr_prod),
		.in_side   ({fr_h[2], fr_h[1], fr_h[0], fr_x[2], fr_x[1], fr_x[0],
			fr_ok, fr_cls, fr_per}),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	for (genvar j = 0; j < 3; j++) begin : g_lane
		assign sq_x[j] = $signed(sq_side[O_X+j*XW +: XW]);
		assign sq_h[j] = sq_side[O_H+j*NORM_W +: NORM_W];
	end

	// integer part of the scaled root is 4*area
	assign sq_area = sq_side[O_OK] ? sq_root[RTW-1:NORM_FRAC] : '0;

	tsf_cordic #(.SW(SW), .AF(ANGLE_FRAC_BITS), .RTW(RTW), .SCW(SC2W)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_root   (sq_root),
		.in_x      (sq_x),
		.in_h      (sq_h),
		.in_ok     (sq_side[O_OK]),
		.in_side   ({sq_area, sq_side[O_CLS +: 2], sq_side[PERW-1:0]}),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ang   (co_ang),
		.out_side  (co_side)
	);

	// a proper triangle has a Heron product of at least one, so its area is
	// never zero while an improper one has its area forced to zero
	logic ok_out;

	assign res_per  = co_side[PERW-1:0];
	assign res_cls  = co_side[PERW +: 2];
	assign res_area = co_side[PERW+2 +: AREAW];

	assign m_axis_tdata = OUT_W'({res_cls, co_ang[2], co_ang[1], co_ang[0], res_area, res_per});
	assign ok_out       = res_area != '0;
	assign m_axis_tuser = ok_out;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			co_ang[0] == '0 && co_ang[1] == '0 && co_ang[2] == '0)
		else $error("invalid triangle with nonzero angle");

	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			co_ang[0] <= ANG_MAX && co_ang[1] <= ANG_MAX && co_ang[2] <= ANG_MAX)
		else $error("angle above 180 degrees");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused while output is free");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res_cls == SHAPE_EQUILATERAL || res_cls == SHAPE_ISOSCELES ||
			res_cls == SHAPE_SCALENE)
		else $error("shape code out of range");

endmodule
